// ===== rtl/core/csvfs_pkg.sv =====
// ----------------------------------------------------------------------------
// csvfs_pkg
// Types and constants shared by the CSV field splitter.
// ----------------------------------------------------------------------------
package csvfs_pkg;

  localparam logic [7:0] QUOTE_BYTE     = 8'h22;
  localparam logic [7:0] ESCAPE_BYTE    = 8'h5C;
  localparam logic [7:0] SPACE_BYTE     = 8'h20;
  localparam logic [7:0] TAB_BYTE       = 8'h09;
  localparam logic [7:0] SEPARATOR_RST  = 8'd44;

  localparam int unsigned CFG_ADDR_W    = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam logic        REG_SEPARATOR = 1'b0;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] field_byte;
    logic       byte_valid;
    logic       field_end;
    logic       text_done;
  } out_item_t;

  typedef struct packed {
    logic      load;
    logic      has_result;
    out_item_t item;
  } res_ctl_t;

endpackage

// ===== rtl/core/csvfs_if.sv =====
// ----------------------------------------------------------------------------
// csvfs_if
// Valid/ready channels for text bytes in and field results out.
// ----------------------------------------------------------------------------
interface csvfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface csvfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] field_byte;
  logic       byte_valid;
  logic       field_end;
  logic       text_done;

  modport source (output valid, output field_byte, output byte_valid, output field_end,
                  output text_done, input ready);
  modport sink   (input valid, input field_byte, input byte_valid, input field_end,
                  input text_done, output ready);
endinterface

// ===== rtl/core/csvfs_cfg.sv =====
// ----------------------------------------------------------------------------
// csvfs_cfg
// APB register file holding the separator byte.
// ----------------------------------------------------------------------------
module csvfs_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [csvfs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [csvfs_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [csvfs_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                              pready,
  output logic [7:0]                        separator
);
  import csvfs_pkg::*;

  logic [7:0] sep_r;
  logic [7:0] sep_nxt;
  logic       wr_en;

  assign wr_en = psel && penable && pwrite && (paddr[2] == REG_SEPARATOR);

  always_comb begin
    sep_nxt = sep_r;
    if (wr_en) begin
      sep_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEPARATOR_RST;
    end else begin
      sep_r <= sep_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SEPARATOR) begin
      prdata = {{(CFG_DATA_W-8){1'b0}}, sep_r};
    end
  end

  assign pready    = 1'b1;
  assign separator = sep_r;

endmodule

// ===== rtl/core/csvfs_core.sv =====
// ----------------------------------------------------------------------------
// csvfs_core
// Input register, parser state and per-byte field split logic.
// ----------------------------------------------------------------------------
module csvfs_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           separator,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  csvfs_pkg::in_item_t  in_item,
  input  logic                 res_can_load,
  output csvfs_pkg::res_ctl_t  res_ctl
);
  import csvfs_pkg::*;

  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_item_r;
  logic     advance;

  logic [7:0] held_byte_r, held_byte_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       inq_r, inq_nxt;
  logic       esc_r, esc_nxt;
  logic       afs_r, afs_nxt;
  logic       skip_r, skip_nxt;
  logic       fwq_r, fwq_nxt;

  logic       has_res;
  out_item_t  res;
  logic       proceed;
  logic       put;
  logic [7:0] b;

  assign advance  = s1_valid_r && res_can_load;
  assign in_ready = !s1_valid_r || res_can_load;
  assign b        = s1_item_r.text_byte;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_comb begin
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    inq_nxt        = inq_r;
    esc_nxt        = esc_r;
    afs_nxt        = afs_r;
    skip_nxt       = skip_r;
    fwq_nxt        = fwq_r;
    has_res        = 1'b0;
    res            = '0;
    proceed        = 1'b1;
    put            = 1'b0;
    if (s1_item_r.end_of_text) begin
      has_res        = 1'b1;
      res.field_end  = 1'b1;
      res.text_done  = 1'b1;
      held_byte_nxt  = '0;
      held_valid_nxt = 1'b0;
      inq_nxt        = 1'b0;
      esc_nxt        = 1'b0;
      afs_nxt        = 1'b1;
      skip_nxt       = 1'b0;
      fwq_nxt        = 1'b0;
    end else begin
      if (skip_r) begin
        if (b == SPACE_BYTE || b == TAB_BYTE) begin
          proceed = 1'b0;
        end else begin
          skip_nxt = 1'b0;
        end
      end
      if (proceed) begin
        if (esc_r) begin
          esc_nxt = 1'b0;
          put     = 1'b1;
        end else if (b == separator && !inq_r) begin
          has_res        = 1'b1;
          res.field_end  = 1'b1;
          held_byte_nxt  = '0;
          held_valid_nxt = 1'b0;
          fwq_nxt        = 1'b0;
          afs_nxt        = 1'b1;
          skip_nxt       = 1'b1;
        end else if (b == QUOTE_BYTE) begin
          inq_nxt = !inq_r;
          if (afs_r) begin
            afs_nxt = 1'b0;
            fwq_nxt = 1'b1;
          end else begin
            put = 1'b1;
          end
        end else begin
          if (b == ESCAPE_BYTE) begin
            esc_nxt = 1'b1;
          end
          put = 1'b1;
        end
      end
      if (put) begin
        afs_nxt = 1'b0;
        if (fwq_r) begin
          if (held_valid_r) begin
            has_res        = 1'b1;
            res.field_byte = held_byte_r;
            res.byte_valid = 1'b1;
          end
          held_byte_nxt  = b;
          held_valid_nxt = 1'b1;
        end else begin
          has_res        = 1'b1;
          res.field_byte = b;
          res.byte_valid = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      held_byte_r  <= '0;
      held_valid_r <= 1'b0;
      inq_r        <= 1'b0;
      esc_r        <= 1'b0;
      afs_r        <= 1'b1;
      skip_r       <= 1'b0;
      fwq_r        <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (advance) begin
        held_byte_r  <= held_byte_nxt;
        held_valid_r <= held_valid_nxt;
        inq_r        <= inq_nxt;
        esc_r        <= esc_nxt;
        afs_r        <= afs_nxt;
        skip_r       <= skip_nxt;
        fwq_r        <= fwq_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  assign res_ctl.load       = advance;
  assign res_ctl.has_result = has_res;
  assign res_ctl.item       = res;

  a_end_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && has_res && res.field_end) |-> (!res.byte_valid && res.field_byte == 8'd0))
    else $error("field end result carries a byte");

  a_eot_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_item_r.end_of_text) |=> (afs_r && !inq_r && !esc_r && !held_valid_r))
    else $error("end of text did not restart parser state");

  a_held_quoted: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> fwq_r)
    else $error("held byte outside a quoted field");

endmodule

// ===== rtl/core/csvfs_out.sv =====
// ----------------------------------------------------------------------------
// csvfs_out
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module csvfs_out (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csvfs_pkg::res_ctl_t  res_ctl,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output csvfs_pkg::out_item_t out_item
);
  import csvfs_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (can_load) begin
      valid_nxt = res_ctl.load && res_ctl.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && res_ctl.load && res_ctl.has_result) begin
      item_r <= res_ctl.item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// ===== rtl/core/csv_field_splitter.sv =====
// ----------------------------------------------------------------------------
// csv_field_splitter
// Splits a byte stream into CSV fields with quote, escape and blank handling.
// ----------------------------------------------------------------------------
// Bytes are parsed from the input register; results load the result register.
// Throughput: one byte per cycle unless output stalls; combinational parse.
// Reset: synchronous active-low rst_n clears the parser and sets the
// separator to a comma; no clearing pass.
// ----------------------------------------------------------------------------
module csv_field_splitter (
  input  logic                              clk,
  input  logic                              rst_n,
  csvfs_in_if.sink                          in_ch,
  csvfs_out_if.source                       out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [csvfs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [csvfs_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [csvfs_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                              pready
);
  import csvfs_pkg::*;

  logic       [7:0] separator;
  logic             can_load;
  logic             in_ready;
  res_ctl_t         res_ctl;
  in_item_t         in_item;
  out_item_t        out_item;
  logic             out_valid;

  assign in_item.text_byte   = in_ch.text_byte;
  assign in_item.end_of_text = in_ch.end_of_text;
  assign in_ch.ready         = in_ready;

  csvfs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .separator (separator)
  );

  csvfs_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .separator    (separator),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .res_can_load (can_load),
    .res_ctl      (res_ctl)
  );

  csvfs_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_ctl   (res_ctl),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.field_byte = out_item.field_byte;
  assign out_ch.byte_valid = out_item.byte_valid;
  assign out_ch.field_end  = out_item.field_end;
  assign out_ch.text_done  = out_item.text_done;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CSV field splitter. A built-in parser
// predicts each field result from the accepted text bytes and tracks the
// separator register. Directed texts cover quoting, escapes, blank
// skipping and end of text. Separator corner values follow. Random
// well-formed texts, mixed with noise, then run under several separators.
// Both channels see random idle and stall bursts.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import csvfs_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] SEP_ADDR = CFG_ADDR_W'(4 * int'(REG_SEPARATOR));

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  csvfs_in_if  in_ch ();
  csvfs_out_if out_ch ();

  csv_field_splitter u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [7:0] sep_byte;
  logic [7:0] hold_byte;
  logic       hold_vld;
  logic       quote_open;
  logic       esc_next;
  logic       fld_start;
  logic       skip_ws;
  logic       fld_quoted;

  out_item_t  field_out_q[$];
  bit         idle_on;
  int         items_sent;
  int         error_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic string fmt_field(input out_item_t f);
    return $sformatf("byte=%02h vld=%b end=%b done=%b",
                     f.field_byte, f.byte_valid, f.field_end, f.text_done);
  endfunction

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  function automatic void clear_text_state();
    hold_byte  = 8'h00;
    hold_vld   = 1'b0;
    quote_open = 1'b0;
    esc_next   = 1'b0;
    fld_start  = 1'b1;
    skip_ws    = 1'b0;
    fld_quoted = 1'b0;
  endfunction

  // Delay value bytes by one in a quoted field so its last byte can be dropped.
  function automatic bit emit_value(input logic [7:0] b, inout out_item_t res);
    bit has;
    has = 1'b0;
    fld_start = 1'b0;
    if (fld_quoted) begin
      if (hold_vld) begin
        res.field_byte = hold_byte;
        res.byte_valid = 1'b1;
        has = 1'b1;
      end
      hold_byte = b;
      hold_vld  = 1'b1;
      return has;
    end
    res.field_byte = b;
    res.byte_valid = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit parse_text_byte(input in_item_t it, output out_item_t res);
    res = '0;
    if (it.end_of_text) begin
      res.field_end = 1'b1;
      res.text_done = 1'b1;
      clear_text_state();
      return 1'b1;
    end
    if (skip_ws) begin
      if (it.text_byte == SPACE_BYTE || it.text_byte == TAB_BYTE) return 1'b0;
      skip_ws = 1'b0;
    end
    if (esc_next) begin
      esc_next = 1'b0;
      return emit_value(it.text_byte, res);
    end
    if (it.text_byte == sep_byte && !quote_open) begin
      res.field_end = 1'b1;
      hold_byte  = 8'h00;
      hold_vld   = 1'b0;
      fld_quoted = 1'b0;
      fld_start  = 1'b1;
      skip_ws    = 1'b1;
      return 1'b1;
    end
    if (it.text_byte == QUOTE_BYTE) begin
      quote_open = !quote_open;
      if (fld_start) begin
        fld_start  = 1'b0;
        fld_quoted = 1'b1;
        return 1'b0;
      end
    end else if (it.text_byte == ESCAPE_BYTE) begin
      esc_next = 1'b1;
    end
    return emit_value(it.text_byte, res);
  endfunction

  function automatic logic [7:0] text_char();
    case ($urandom_range(0, 13))
      0:       return QUOTE_BYTE;
      1:       return ESCAPE_BYTE;
      2:       return SPACE_BYTE;
      3:       return TAB_BYTE;
      4:       return sep_byte;
      5, 6:    return 8'($urandom_range(0, 255));
      default: return 8'(8'h61 + $urandom_range(0, 25));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eot);
    in_item_t  item;
    out_item_t res;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
    item.text_byte   = b;
    item.end_of_text = eot;
    if (parse_text_byte(item, res)) field_out_q.push_back(res);
    items_sent++;
  endtask

  task automatic send_text(input string s, input bit end_it);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    if (end_it) send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic drain_fields();
    in_ch.valid <= 1'b0;
    for (int i = 0; i < 20000 && field_out_q.size() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEP_ADDR;
    pwdata  <= CFG_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sep_byte = val;
  endtask

  task automatic cfg_check(input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= SEP_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DATA_W'(val))
      flag_error($sformatf("separator readback: expected %08h, got %08h",
                           CFG_DATA_W'(val), prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_separator(input logic [7:0] val);
    drain_fields();
    cfg_write(val);
    cfg_check(val);
  endtask

  task automatic test_register_defaults();
    cfg_check(SEPARATOR_RST);
  endtask

  task automatic test_directed_fields();
    send_text("a,b", 1'b1);
    send_text("\"x,y\",", 1'b0);
    send_text(" \t\\,", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("\"", 1'b1);
    send_text("\\", 1'b1);
    send_text(", ", 1'b1);
  endtask

  task automatic test_separator_corners();
    logic [7:0] corner[5];
    logic [7:0] seq[$];
    corner = '{TAB_BYTE, QUOTE_BYTE, ESCAPE_BYTE, 8'h00, 8'hFF};
    foreach (corner[k]) begin
      set_separator(corner[k]);
      seq = '{8'h61, corner[k], corner[k], SPACE_BYTE, 8'h62, corner[k], QUOTE_BYTE,
              8'h71, corner[k], 8'h71, QUOTE_BYTE, corner[k], ESCAPE_BYTE, corner[k],
              8'h63};
      foreach (seq[i]) send_byte(seq[i], 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic test_random_texts(input int n_items);
    int start;
    int n_fields;
    int len;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      end else begin
        n_fields = $urandom_range(1, 5);
        for (int f = 0; f < n_fields; f++) begin
          if (f != 0) begin
            send_byte(sep_byte, 1'b0);
            repeat ($urandom_range(0, 2))
              send_byte($urandom_range(0, 1) ? SPACE_BYTE : TAB_BYTE, 1'b0);
          end
          len = $urandom_range(0, 6);
          if ($urandom_range(0, 2) == 0) begin
            send_byte(QUOTE_BYTE, 1'b0);
            repeat (len) send_byte(text_char(), 1'b0);
            send_byte(QUOTE_BYTE, 1'b0);
          end else begin
            repeat (len) send_byte(text_char(), 1'b0);
          end
        end
        if ($urandom_range(0, 7) != 0) send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endtask

  initial begin
    int stall;
    out_item_t got;
    out_item_t exp;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.field_byte = out_ch.field_byte;
        got.byte_valid = out_ch.byte_valid;
        got.field_end  = out_ch.field_end;
        got.text_done  = out_ch.text_done;
        if (field_out_q.size() == 0) begin
          flag_error($sformatf("unexpected field result: %s", fmt_field(got)));
        end else begin
          exp = field_out_q.pop_front();
          if (got.field_byte !== exp.field_byte || got.byte_valid !== exp.byte_valid ||
              got.field_end !== exp.field_end || got.text_done !== exp.text_done)
            flag_error($sformatf("field result: expected %s, got %s",
                                 fmt_field(exp), fmt_field(got)));
        end
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 8);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.text_byte   = 8'h00;
    in_ch.end_of_text = 1'b0;
    idle_on           = 1'b1;
    items_sent        = 0;
    error_count       = 0;
    sep_byte          = SEPARATOR_RST;
    clear_text_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_defaults();
    test_directed_fields();
    test_separator_corners();
    set_separator(SEPARATOR_RST);
    test_random_texts(130);
    set_separator(TAB_BYTE);
    test_random_texts(150);
    set_separator(8'h00);
    test_random_texts(130);
    set_separator(8'hFF);
    test_random_texts(120);
    set_separator(8'($urandom_range(0, 255)));
    test_random_texts(100);
    set_separator(SEPARATOR_RST);
    idle_on = 1'b0;
    test_random_texts(120);

    drain_fields();
    if (field_out_q.size() != 0)
      flag_error($sformatf("%0d field results never arrived", field_out_q.size()));
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/csvfs_pkg.sv
rtl/core/csvfs_if.sv
rtl/core/csvfs_cfg.sv
rtl/core/csvfs_core.sv
rtl/core/csvfs_out.sv
rtl/core/csv_field_splitter.sv
tb/sv/tb_top.sv
